// ===== design/ipsw_pkg.sv =====
// Shared types, constants and byte helpers for the indexed PNG stream writer.
package ipsw_pkg;

  localparam int unsigned PALETTE_DEPTH    = 256;
  localparam int unsigned STORED_BLOCK_MAX = 65535;
  localparam int unsigned MIN_PALETTE      = 16;
  localparam int unsigned QUEUE_DEPTH      = 4;

  localparam logic [16:0] AdlerMod   = 17'd65521;
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [15:0] BlockMax   = 16'(STORED_BLOCK_MAX);
  localparam logic [29:0] BlockMax30 = 30'(STORED_BLOCK_MAX);

  typedef enum logic [1:0] {
    CMD_PAL_WR = 2'd0,
    CMD_START  = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_PALSIZE = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_SIG       = 5'd1,
    PH_IHDR_LEN  = 5'd2,
    PH_IHDR_BODY = 5'd3,
    PH_IHDR_CRC  = 5'd4,
    PH_PLTE_LEN  = 5'd5,
    PH_PLTE_BODY = 5'd6,
    PH_PLTE_CRC  = 5'd7,
    PH_TRNS_LEN  = 5'd8,
    PH_TRNS_BODY = 5'd9,
    PH_TRNS_CRC  = 5'd10,
    PH_IDAT_LEN  = 5'd11,
    PH_IDAT_TYPE = 5'd12,
    PH_ZHDR      = 5'd13,
    PH_BLK_HDR   = 5'd14,
    PH_DATA      = 5'd15,
    PH_ADLER     = 5'd16,
    PH_IDAT_CRC  = 5'd17,
    PH_IEND_LEN  = 5'd18,
    PH_IEND_TYPE = 5'd19,
    PH_IEND_CRC  = 5'd20
  } phase_e;

  typedef enum logic [1:0] {
    SRC_LIT = 2'd0,
    SRC_PAL = 2'd1,
    SRC_CRC = 2'd2
  } src_e;

  // Request as it travels from the front queue to the back end.
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  idx;
    logic [31:0] argb;
    logic [7:0]  pix;
  } item_t;

  // Byte descriptor between the sequencer and the output stage.
  typedef struct packed {
    src_e       src;
    logic [7:0] lit;
    logic [1:0] sel;      // palette lane (3 = alpha) or crc byte position
    logic       zero;     // palette entry past the supplied count
    logic       crc_en;
    logic       crc_init;
    logic       taken;
    logic       eoi;
  } byte_t;

  function automatic logic [7:0] be8(input logic [31:0] v, input logic [1:0] p);
    logic [7:0] r;
    case (p)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = 8'h89;
      3'd1:    r = 8'h50;
      3'd2:    r = 8'h4E;
      3'd3:    r = 8'h47;
      3'd4:    r = 8'h0D;
      3'd5:    r = 8'h0A;
      3'd6:    r = 8'h1A;
      default: r = 8'h0A;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] name_byte(input logic [31:0] n, input logic [1:0] p);
    return be8(n, p);
  endfunction

  localparam logic [31:0] NameIhdr = 32'h49484452;
  localparam logic [31:0] NamePlte = 32'h504C5445;
  localparam logic [31:0] NameTrns = 32'h74524E53;
  localparam logic [31:0] NameIdat = 32'h49444154;
  localparam logic [31:0] NameIend = 32'h49454E44;

endpackage

// ===== design/ipsw_ram.sv =====
// Generic single-write, registered-read RAM.
module ipsw_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ipsw_front.sv =====
// Input side: takes requests, drops unknown commands, queues the rest.
module ipsw_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [7:0]           palette_index_i,
  input  logic [31:0]          argb_value_i,
  input  logic [7:0]           pixel_value_i,
  output logic                 head_valid_o,
  output ipsw_pkg::item_t      head_o,
  input  logic                 pop_i
);

  localparam int unsigned Depth = ipsw_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);

  ipsw_pkg::item_t fifo_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            acc, push, pop;

  assign in_stall_o   = (cnt_q == (PtrW+1)'(Depth));
  assign acc          = in_valid_i && !in_stall_o;
  assign push         = acc && (ipsw_pkg::cmd_e'(command_i) != ipsw_pkg::CMD_NONE);
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{cmd: ipsw_pkg::cmd_e'(command_i), idx: palette_index_i,
                        argb: argb_value_i, pix: pixel_value_i};
    end
  end

endmodule

// ===== design/ipsw_back.sv =====
// Back end: file sequencer, palette memory, CRC and output register.
module ipsw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [14:0]      width_i,
  input  logic [14:0]      height_i,
  input  logic [8:0]       pal_size_i,
  input  logic             head_valid_i,
  input  ipsw_pkg::item_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             pixel_taken_o,
  output logic             end_of_image_o
);

  ipsw_pkg::phase_e phase_q, phase_d;
  logic [9:0]  pos_q, pos_d;
  logic [8:0]  ent_q, ent_d;
  logic [1:0]  comp_q, comp_d;
  logic [15:0] alo_q, alo_d, ahi_q, ahi_d;
  logic [15:0] blk_q, blk_d;
  logic [29:0] br_q, br_d;
  logic [14:0] col_q, col_d;
  logic [14:0] quot_q;
  logic [31:0] idat_len_q;

  logic p_valid_q;
  ipsw_pkg::byte_t p_q, meta;
  logic out_valid_q;
  logic [7:0] obyte_q;
  logic otaken_q, oeoi_q;
  logic [31:0] crc_q;

  logic out_ready, p_ready, active, is_step, emit, adv;
  logic [8:0]  ce;
  logic [9:0]  ce3;
  logic [10:0] sec_len, pos_n;
  logic [7:0]  dbyte;
  logic [16:0] lo_s, hi_s;
  logic [15:0] lo_n, hi_n;
  logic        fin;
  logic [15:0] blen;
  logic [31:0] rdata;
  logic [7:0]  pal_b, fbyte;
  logic [30:0] qsum;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign p_ready   = !p_valid_q || out_ready;
  assign active    = (phase_q != ipsw_pkg::PH_IDLE);
  assign is_step   = (head_i.cmd == ipsw_pkg::CMD_STEP);
  assign emit      = head_valid_i && is_step && active;
  assign pop_o     = head_valid_i && (!is_step || !active || p_ready);
  assign adv       = emit && p_ready;

  // Palette entries carried by PLTE and tRNS, clamped to 16..256.
  always_comb begin
    if (pal_size_i < 9'(ipsw_pkg::MIN_PALETTE)) begin
      ce = 9'(ipsw_pkg::MIN_PALETTE);
    end else if (pal_size_i > 9'(ipsw_pkg::PALETTE_DEPTH)) begin
      ce = 9'(ipsw_pkg::PALETTE_DEPTH);
    end else begin
      ce = pal_size_i;
    end
    ce3 = {1'b0, ce} + {ce, 1'b0};
  end

  always_comb begin
    case (phase_q)
      ipsw_pkg::PH_SIG:       sec_len = 11'd8;
      ipsw_pkg::PH_IHDR_BODY: sec_len = 11'd17;
      ipsw_pkg::PH_PLTE_BODY: sec_len = 11'd4 + {1'b0, ce3};
      ipsw_pkg::PH_TRNS_BODY: sec_len = 11'd4 + {2'b0, ce};
      ipsw_pkg::PH_ZHDR:      sec_len = 11'd2;
      ipsw_pkg::PH_BLK_HDR:   sec_len = 11'd5;
      default:                sec_len = 11'd4;
    endcase
  end

  // Stored-block header fields and image data byte with Adler update.
  assign fin   = (br_q <= ipsw_pkg::BlockMax30);
  assign blen  = fin ? br_q[15:0] : ipsw_pkg::BlockMax;
  assign dbyte = (col_q == '0) ? 8'd0 : head_i.pix;
  always_comb begin
    lo_s = {1'b0, alo_q} + {9'd0, dbyte};
    lo_n = (lo_s >= ipsw_pkg::AdlerMod) ? 16'(lo_s - ipsw_pkg::AdlerMod) : lo_s[15:0];
    hi_s = {1'b0, ahi_q} + {1'b0, lo_n};
    hi_n = (hi_s >= ipsw_pkg::AdlerMod) ? 16'(hi_s - ipsw_pkg::AdlerMod) : hi_s[15:0];
  end

  // Byte descriptor for the current position.
  always_comb begin
    meta = '{src: ipsw_pkg::SRC_LIT, lit: 8'd0, sel: pos_q[1:0], zero: 1'b0,
             crc_en: 1'b0, crc_init: 1'b0, taken: 1'b0, eoi: 1'b0};
    case (phase_q)
      ipsw_pkg::PH_SIG: meta.lit = ipsw_pkg::sig_byte(pos_q[2:0]);
      ipsw_pkg::PH_IHDR_LEN: begin
        meta.lit      = ipsw_pkg::be8(32'd13, pos_q[1:0]);
        meta.crc_init = 1'b1;
      end
      ipsw_pkg::PH_IHDR_BODY: begin
        meta.crc_en = 1'b1;
        if (pos_q < 10'd4) begin
          meta.lit = ipsw_pkg::name_byte(ipsw_pkg::NameIhdr, pos_q[1:0]);
        end else if (pos_q < 10'd8) begin
          meta.lit = ipsw_pkg::be8({17'd0, width_i}, pos_q[1:0]);
        end else if (pos_q < 10'd12) begin
          meta.lit = ipsw_pkg::be8({17'd0, height_i}, pos_q[1:0]);
        end else if (pos_q == 10'd12) begin
          meta.lit = 8'd8;
        end else if (pos_q == 10'd13) begin
          meta.lit = 8'd3;
        end
      end
      ipsw_pkg::PH_PLTE_LEN: begin
        meta.lit      = ipsw_pkg::be8({22'd0, ce3}, pos_q[1:0]);
        meta.crc_init = 1'b1;
      end
      ipsw_pkg::PH_PLTE_BODY: begin
        meta.crc_en = 1'b1;
        if (pos_q < 10'd4) begin
          meta.lit = ipsw_pkg::name_byte(ipsw_pkg::NamePlte, pos_q[1:0]);
        end else begin
          meta.src  = ipsw_pkg::SRC_PAL;
          meta.sel  = comp_q;
          meta.zero = !((ent_q < ce) && (ent_q < pal_size_i));
        end
      end
      ipsw_pkg::PH_TRNS_LEN: begin
        meta.lit      = ipsw_pkg::be8({23'd0, ce}, pos_q[1:0]);
        meta.crc_init = 1'b1;
      end
      ipsw_pkg::PH_TRNS_BODY: begin
        meta.crc_en = 1'b1;
        if (pos_q < 10'd4) begin
          meta.lit = ipsw_pkg::name_byte(ipsw_pkg::NameTrns, pos_q[1:0]);
        end else begin
          meta.src  = ipsw_pkg::SRC_PAL;
          meta.sel  = 2'd3;
          meta.zero = !((ent_q < ce) && (ent_q < pal_size_i));
        end
      end
      ipsw_pkg::PH_IDAT_LEN: begin
        meta.lit      = ipsw_pkg::be8(idat_len_q, pos_q[1:0]);
        meta.crc_init = 1'b1;
      end
      ipsw_pkg::PH_IDAT_TYPE: begin
        meta.lit    = ipsw_pkg::name_byte(ipsw_pkg::NameIdat, pos_q[1:0]);
        meta.crc_en = 1'b1;
      end
      ipsw_pkg::PH_ZHDR: begin
        meta.lit    = (pos_q == '0) ? 8'h78 : 8'hDA;
        meta.crc_en = 1'b1;
      end
      ipsw_pkg::PH_BLK_HDR: begin
        meta.crc_en = 1'b1;
        case (pos_q[2:0])
          3'd0:    meta.lit = {7'd0, fin};
          3'd1:    meta.lit = blen[7:0];
          3'd2:    meta.lit = blen[15:8];
          3'd3:    meta.lit = ~blen[7:0];
          default: meta.lit = ~blen[15:8];
        endcase
      end
      ipsw_pkg::PH_DATA: begin
        meta.lit    = dbyte;
        meta.taken  = (col_q != '0);
        meta.crc_en = 1'b1;
      end
      ipsw_pkg::PH_ADLER: begin
        meta.lit    = ipsw_pkg::be8({ahi_q, alo_q}, pos_q[1:0]);
        meta.crc_en = 1'b1;
      end
      ipsw_pkg::PH_IEND_LEN: meta.crc_init = 1'b1;
      ipsw_pkg::PH_IEND_TYPE: begin
        meta.lit    = ipsw_pkg::name_byte(ipsw_pkg::NameIend, pos_q[1:0]);
        meta.crc_en = 1'b1;
      end
      ipsw_pkg::PH_IEND_CRC: begin
        meta.src = ipsw_pkg::SRC_CRC;
        meta.eoi = (pos_q == 10'd3);
      end
      default: meta.src = ipsw_pkg::SRC_CRC;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    ent_d   = ent_q;
    comp_d  = comp_q;
    alo_d   = alo_q;
    ahi_d   = ahi_q;
    blk_d   = blk_q;
    br_d    = br_q;
    col_d   = col_q;
    pos_n   = {1'b0, pos_q} + 11'd1;
    if (pop_o && head_i.cmd == ipsw_pkg::CMD_START) begin
      phase_d = ipsw_pkg::PH_SIG;
      pos_d   = '0;
      ent_d   = '0;
      comp_d  = '0;
      alo_d   = 16'd1;
      ahi_d   = '0;
      blk_d   = '0;
      br_d    = 30'(height_i * ({1'b0, width_i} + 16'd1));
      col_d   = '0;
    end else if (adv && phase_q == ipsw_pkg::PH_DATA) begin
      alo_d = lo_n;
      ahi_d = hi_n;
      col_d = (col_q >= width_i) ? '0 : col_q + 15'd1;
      blk_d = blk_q + 16'd1;
      br_d  = (br_q != '0) ? br_q - 30'd1 : br_q;
      if (blk_d == ipsw_pkg::BlockMax) begin
        phase_d = ipsw_pkg::PH_BLK_HDR;
        pos_d   = '0;
      end else if (br_d == '0) begin
        phase_d = ipsw_pkg::PH_ADLER;
        pos_d   = '0;
      end
    end else if (adv) begin
      pos_d = pos_n[9:0];
      if (pos_q >= 10'd4 && phase_q == ipsw_pkg::PH_PLTE_BODY) begin
        if (comp_q == 2'd2) begin
          comp_d = '0;
          ent_d  = ent_q + 9'd1;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      if (pos_q >= 10'd4 && phase_q == ipsw_pkg::PH_TRNS_BODY) begin
        ent_d = ent_q + 9'd1;
      end
      if (pos_n >= sec_len) begin
        pos_d  = '0;
        ent_d  = '0;
        comp_d = '0;
        if (phase_q == ipsw_pkg::PH_BLK_HDR) begin
          blk_d   = '0;
          phase_d = (br_q == '0) ? ipsw_pkg::PH_ADLER : ipsw_pkg::PH_DATA;
        end else if (phase_q == ipsw_pkg::PH_IEND_CRC) begin
          phase_d = ipsw_pkg::PH_IDLE;
        end else begin
          phase_d = ipsw_pkg::phase_e'(5'(phase_q) + 5'd1);
        end
      end
    end
  end

  // IDAT length: bytes + 11 + 5 * floor(bytes / 65535), settled long before it is sent.
  assign qsum = {1'b0, br_q} + {17'd0, br_q[29:16]} + 31'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ipsw_pkg::PH_IDLE;
      pos_q       <= '0;
      ent_q       <= '0;
      comp_q      <= '0;
      alo_q       <= 16'd1;
      ahi_q       <= '0;
      blk_q       <= '0;
      br_q        <= '0;
      col_q       <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= '1;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      ent_q   <= ent_d;
      comp_q  <= comp_d;
      alo_q   <= alo_d;
      ahi_q   <= ahi_d;
      blk_q   <= blk_d;
      br_q    <= br_d;
      col_q   <= col_d;
      if (p_ready) begin
        p_valid_q <= adv;
      end
      if (out_ready) begin
        out_valid_q <= p_valid_q;
        if (p_valid_q) begin
          if (p_q.crc_init) begin
            crc_q <= '1;
          end else if (p_q.crc_en) begin
            crc_q <= ipsw_pkg::crc_byte(crc_q, fbyte);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q     <= qsum[30:16];
    idat_len_q <= {2'd0, br_q} + 32'd11 + {15'd0, quot_q, 2'd0} + {17'd0, quot_q};
    if (p_ready && adv) begin
      p_q <= meta;
    end
    if (out_ready && p_valid_q) begin
      obyte_q  <= fbyte;
      otaken_q <= p_q.taken;
      oeoi_q   <= p_q.eoi;
    end
  end

  ipsw_ram #(
    .Width (32),
    .Depth (ipsw_pkg::PALETTE_DEPTH)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (pop_o && head_i.cmd == ipsw_pkg::CMD_PAL_WR),
    .waddr_i (head_i.idx),
    .wdata_i (head_i.argb),
    .re_i    (adv),
    .raddr_i (ent_q[7:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    case (p_q.sel)
      2'd0:    pal_b = rdata[23:16];
      2'd1:    pal_b = rdata[15:8];
      2'd2:    pal_b = rdata[7:0];
      default: pal_b = rdata[31:24];
    endcase
    case (p_q.src)
      ipsw_pkg::SRC_PAL: fbyte = p_q.zero ? 8'd0 : pal_b;
      ipsw_pkg::SRC_CRC: fbyte = ipsw_pkg::be8(~crc_q, p_q.sel);
      default:           fbyte = p_q.lit;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = obyte_q;
  assign pixel_taken_o  = otaken_q;
  assign end_of_image_o = oeoi_q;

endmodule

// ===== design/indexed_png_stored_stream_writer_top.sv =====
// Top level of the indexed PNG writer with an uncompressed zlib payload.
// Requests arrive on in_valid_i/in_stall_o: command 0 writes a palette entry,
// command 1 starts a new image, command 2 asks for the next file byte.
// Command 3 and steps while no image is running are taken and dropped.
// Each step during an image gives one result on out_valid_o/out_stall_i:
// the byte, whether pixel_value_i was consumed, and end_of_image_o on the
// final IEND byte. Width, height and palette size are written through
// cfg_we_i/cfg_idx_i/cfg_data_i; the user must do so only while no request is
// outstanding; the block does not enforce this. Steps pass from the queue
// through the byte stage into the output register. One request per cycle
// is sustained while out_stall_i is low; the four-entry request queue and a
// one-entry byte stage between sequencer and output register absorb stalls.
// A stalled receiver holds the output register; once the stages fill,
// in_stall_o rises. Reset empties all stages, returns to idle and restores
// width 1, height 1, palette size 16. Palette contents are not cleared.
module indexed_png_stored_stream_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  palette_index_i,
  input  logic [31:0] argb_value_i,
  input  logic [7:0]  pixel_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        pixel_taken_o,
  output logic        end_of_image_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  logic [14:0] width_q, height_q;
  logic [8:0]  pal_size_q;
  logic            head_valid, pop;
  ipsw_pkg::item_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 15'd1;
      height_q   <= 15'd1;
      pal_size_q <= 9'd16;
    end else if (cfg_we_i) begin
      case (ipsw_pkg::cfg_idx_e'(cfg_idx_i))
        ipsw_pkg::CFG_WIDTH:   width_q    <= cfg_data_i;
        ipsw_pkg::CFG_HEIGHT:  height_q   <= cfg_data_i;
        ipsw_pkg::CFG_PALSIZE: pal_size_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  ipsw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .palette_index_i (palette_index_i),
    .argb_value_i    (argb_value_i),
    .pixel_value_i   (pixel_value_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  ipsw_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .width_i        (width_q),
    .height_i       (height_q),
    .pal_size_i     (pal_size_q),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .pixel_taken_o  (pixel_taken_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule
